@@ src/canrxaf_pkg.sv @@
// ----------------------------------------------------------------------------
// canrxaf_pkg
// Shared types and codes for the CAN receive acceptance filter.
// ----------------------------------------------------------------------------
`default_nettype none

package canrxaf_pkg;

	// Input transaction
	typedef struct packed {
		logic        func;
		logic [3:0]  index;
		logic [10:0] ident;
		logic [10:0] mask;
		logic        rtr;
		logic        handler_bound;
		logic [3:0]  dlc;
		logic [63:0] payload;
	} item_t;

	// Result transaction
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  entry;
		logic [10:0] frame_ident;
		logic [3:0]  frame_length;
		logic [63:0] frame_data;
	} result_t;

	// Entry write broadcast to the cell row (identifier and mask already
	// carry the RTR bit)
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic [11:0] ident;
		logic [11:0] mask;
	} wr_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic        bound;
		logic [3:0]  entry;
		logic [10:0] ident;
	} tok_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_HOLD
	} fsm_t;

	// Item function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	// Configuration register indexes
	localparam logic REG_NORMAL_MODE    = 1'b0;
	localparam logic REG_ENTRIES_IN_USE = 1'b1;

	// Result status codes
	localparam logic [2:0] STAT_WRITTEN   = 3'd0;
	localparam logic [2:0] STAT_BAD_WRITE = 3'd1;
	localparam logic [2:0] STAT_DROPPED   = 3'd2;
	localparam logic [2:0] STAT_NO_MATCH  = 3'd3;
	localparam logic [2:0] STAT_UNBOUND   = 3'd4;
	localparam logic [2:0] STAT_DELIVERED = 3'd5;

	// Constants
	localparam logic [11:0] RTR_BIT       = 12'h800;
	localparam logic [11:0] MASK_RESET    = 12'hFFF;
	localparam logic [3:0]  MAX_LEN       = 4'd8;
	localparam logic [4:0]  ENTRIES_RESET = 5'd16;

endpackage

`default_nettype wire

@@ src/canrxaf_cell.sv @@
// ----------------------------------------------------------------------------
// canrxaf_cell
// One filter entry: stores identifier, mask and bound flag, compares the
// passing search token and registers it toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module canrxaf_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire canrxaf_pkg::wr_t  wr,
	input  wire logic [4:0]        entries_in_use,
	input  wire canrxaf_pkg::tok_t tok_in,
	output canrxaf_pkg::tok_t      tok_out
);

	logic [11:0]       ident_q;
	logic [11:0]       mask_q;
	logic              bound_q;
	logic              valid_q;
	canrxaf_pkg::tok_t data_q;
	canrxaf_pkg::tok_t tok_next;
	logic              active;
	logic              sel;
	logic              match;

	// entry lies inside the searched range
	assign active = IDX < int'(entries_in_use);
	assign sel    = wr.en && (int'(wr.index) == IDX);
	// frames carry no RTR bit, so bit 11 of the frame side is zero
	assign match  = ((({1'b0, tok_in.ident}) ^ ident_q) & mask_q) == 12'h000;

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= '0;
			mask_q  <= canrxaf_pkg::MASK_RESET;
			bound_q <= 1'b0;
		end else if (sel) begin
			ident_q <= wr.ident;
			mask_q  <= wr.mask;
			bound_q <= 1'b1;
		end
	end

	// first hit along the row claims the token
	always_comb begin
		tok_next = tok_in;
		if (tok_in.valid && !tok_in.hit && active && match) begin
			tok_next.hit   = 1'b1;
			tok_next.bound = bound_q;
			tok_next.entry = 4'(IDX);
		end
	end

	// token register: valid is control, the rest is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= tok_next;
	end

	always_comb begin
		tok_out       = data_q;
		tok_out.valid = valid_q;
	end

endmodule

`default_nettype wire

@@ src/can_rx_acceptance_filter_unit.sv @@
// ----------------------------------------------------------------------------
// can_rx_acceptance_filter_unit
// CAN 11-bit identifier/mask receive acceptance filter built as a row of
// filter cells that a search token walks through.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. An entry write or a frame
// dropped outside normal mode is loaded into the pending result register
// when it is taken and moves on to the output register from the hold
// state; the next input transaction is taken only after that move. A frame
// in normal mode instead sends its search token through the row of ENTRIES
// filter cells one cell per clock, and the lowest matching entry claims it
// on the way; the result then passes the pending and output registers.
// A new input transaction is taken while an earlier result still waits in
// the output register; item_stall is high from acceptance until the result
// has moved to that register. Configuration writes are taken in every
// cycle.
`default_nettype none

module can_rx_acceptance_filter_unit #(
	parameter int ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input transactions
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire canrxaf_pkg::item_t   item,
	// result transactions
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output canrxaf_pkg::result_t      result,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [4:0]           cfg_data
);

	canrxaf_pkg::fsm_t    state_q;
	canrxaf_pkg::fsm_t    state_next;
	logic                 normal_mode_q;
	logic [4:0]           entries_in_use_q;
	canrxaf_pkg::result_t pend_q;
	canrxaf_pkg::result_t result_q;
	logic                 result_valid_q;
	logic [3:0]           len_q;
	logic [63:0]          payload_q;

	logic                 accept;
	logic                 wr_ok;
	logic                 start_scan;
	logic                 out_free;
	logic                 load_imm;
	logic                 load_scan;
	logic                 load_out;
	canrxaf_pkg::wr_t     wr;
	canrxaf_pkg::result_t imm_res;
	canrxaf_pkg::result_t scan_res;
	canrxaf_pkg::tok_t    head;
	canrxaf_pkg::tok_t    chain [ENTRIES+1];
	canrxaf_pkg::tok_t    last;
	logic [ENTRIES-1:0]   tok_vld;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_mode_q    <= 1'b0;
			entries_in_use_q <= canrxaf_pkg::ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				canrxaf_pkg::REG_NORMAL_MODE:    normal_mode_q    <= cfg_data[0];
				canrxaf_pkg::REG_ENTRIES_IN_USE: entries_in_use_q <= cfg_data;
				default:                         normal_mode_q    <= normal_mode_q;
			endcase
		end
	end

	assign accept = item_valid && !item_stall;

	// write check: bound consumer, index inside the active and built range
	assign wr_ok = item.handler_bound && ({1'b0, item.index} < entries_in_use_q)
		&& (int'(item.index) < ENTRIES);
	assign start_scan = accept && (item.func == canrxaf_pkg::FUNC_FRAME) && normal_mode_q;

	// entry write broadcast
	always_comb begin
		wr.en    = accept && (item.func == canrxaf_pkg::FUNC_WRITE) && wr_ok;
		wr.index = item.index;
		wr.ident = {1'b0, item.ident} | (item.rtr ? canrxaf_pkg::RTR_BIT : 12'h000);
		wr.mask  = {1'b0, item.mask} | canrxaf_pkg::RTR_BIT;
	end

	// token injected at the head of the row
	always_comb begin
		head       = '0;
		head.valid = start_scan;
		head.ident = item.ident;
	end

	assign chain[0] = head;

	// row of filter cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		canrxaf_cell #(
			.IDX (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.wr             (wr),
			.entries_in_use (entries_in_use_q),
			.tok_in         (chain[i]),
			.tok_out        (chain[i+1])
		);
		assign tok_vld[i] = chain[i+1].valid;
	end

	assign last = chain[ENTRIES];

	// frame length and data held while the token travels
	always_ff @(posedge clk) begin
		if (start_scan) begin
			len_q     <= (item.dlc > canrxaf_pkg::MAX_LEN) ? canrxaf_pkg::MAX_LEN : item.dlc;
			payload_q <= item.payload;
		end
	end

	// result for writes and dropped frames
	always_comb begin
		imm_res = '0;
		if (item.func == canrxaf_pkg::FUNC_WRITE) begin
			imm_res.status = wr_ok ? canrxaf_pkg::STAT_WRITTEN : canrxaf_pkg::STAT_BAD_WRITE;
			imm_res.entry  = item.index;
		end else begin
			imm_res.status = canrxaf_pkg::STAT_DROPPED;
		end
	end

	// result from the token leaving the row
	always_comb begin
		scan_res = '0;
		if (!last.hit) begin
			scan_res.status = canrxaf_pkg::STAT_NO_MATCH;
		end else if (!last.bound) begin
			scan_res.status = canrxaf_pkg::STAT_UNBOUND;
			scan_res.entry  = last.entry;
		end else begin
			scan_res.status       = canrxaf_pkg::STAT_DELIVERED;
			scan_res.entry        = last.entry;
			scan_res.frame_ident  = last.ident;
			scan_res.frame_length = len_q;
			// bytes past the length read as zero
			for (int b = 0; b < 8; b++) begin
				scan_res.frame_data[8*b +: 8] = (4'(b) < len_q) ? payload_q[8*b +: 8] : 8'h00;
			end
		end
	end

	// sequencer: next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			canrxaf_pkg::FSM_IDLE: begin
				if (accept) begin
					state_next = start_scan ? canrxaf_pkg::FSM_SCAN : canrxaf_pkg::FSM_HOLD;
				end
			end
			canrxaf_pkg::FSM_SCAN: begin
				if (last.valid) begin
					state_next = canrxaf_pkg::FSM_HOLD;
				end
			end
			canrxaf_pkg::FSM_HOLD: begin
				if (out_free) begin
					state_next = canrxaf_pkg::FSM_IDLE;
				end
			end
			default: state_next = canrxaf_pkg::FSM_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		item_stall = 1'b1;
		load_imm   = 1'b0;
		load_scan  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			canrxaf_pkg::FSM_IDLE: begin
				item_stall = 1'b0;
				load_imm   = accept && !start_scan;
			end
			canrxaf_pkg::FSM_SCAN: load_scan = last.valid;
			canrxaf_pkg::FSM_HOLD: load_out  = out_free;
			default:               item_stall = 1'b1;
		endcase
	end

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= canrxaf_pkg::FSM_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (load_imm) begin
			pend_q <= imm_res;
		end else if (load_scan) begin
			pend_q <= scan_res;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// at most one search token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in the cell row");

	// a token is in flight exactly while scanning
	a_scan_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == canrxaf_pkg::FSM_SCAN) |-> $onehot(tok_vld))
		else $error("scan state without a search token");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != canrxaf_pkg::FSM_SCAN) |-> (tok_vld == '0))
		else $error("search token outside the scan state");

	// a new result only comes from the hold state
	a_rise_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == canrxaf_pkg::FSM_HOLD))
		else $error("result appeared without a pending result");

	// frame fields are zero unless the frame is delivered
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.status != canrxaf_pkg::STAT_DELIVERED))
		|-> (result_q.frame_data == '0 && result_q.frame_length == '0
			&& result_q.frame_ident == '0))
		else $error("frame fields set on an undelivered result");

endmodule

`default_nettype wire
